@@ hw/rtl/rolling_zscore_momentum_macros.svh @@
// Assertion macros shared by the checker of the rolling z-score block.
// Included by the checker file only; no dependencies.
`ifndef ROLLING_ZSCORE_MOMENTUM_MACROS_SVH
`define ROLLING_ZSCORE_MOMENTUM_MACROS_SVH

// Clocked, reset-gated implication check.
`define RZM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Clocked, reset-gated next-cycle implication check.
`define RZM_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/rzm_pkg.sv @@
// Shared types and constants for the rolling z-score / momentum block.
// No dependencies.
package rzm_pkg;
  localparam int WindowMaxDefault = 64;
  localparam int PriceW = 24;
  localparam int StampW = 64;
  localparam int CfgW = 7;
  localparam logic [CfgW-1:0] WindowReset = 7'd20;

  // Controller to datapath commands
  typedef struct packed {
    logic load;       // capture request price and timestamp
    logic rd_old;     // read oldest slot for removal
    logic rm_old;     // remove captured oldest from sums
    logic add_new;    // write new price, add to sums
    logic rd_base;    // read momentum base slot
    logic div_start;  // start divider sequence
    logic out_load;   // load result register
  } rzm_cmd_t;

  typedef struct packed {
    logic do_remove;  // window full: drop oldest first
    logic emit;       // result produced for this request
    logic calc_done;  // arithmetic finished
  } rzm_sts_t;
endpackage

@@ hw/rtl/rolling_zscore_momentum.sv @@
// Rolling z-score and momentum top level: controller plus datapath.
// Depends on rzm_pkg, rzm_ctrl, rzm_datapath.
// A result takes four divides (mean, mean square, momentum, z-score) and a
// square root in sequence; the z-score divide is skipped when the deviation is zero.
// A new tick is taken only when the previous one is finished and the output is not stalled.
// Reset (rst, synchronous): clears fill count, write slot, sums, window = 20.
module rolling_zscore_momentum #(
  parameter int WindowMax = rzm_pkg::WindowMaxDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [87:0] s_tdata,   // price[23:0], timestamp[87:24]
  output logic m_tvalid,
  input  logic m_tready,
  output logic [127:0] m_tdata,  // momentum[31:0], zscore[63:32], stamp_out[127:64]
  output logic m_tuser,          // zero_base
  input  logic cfg_we,
  input  logic [rzm_pkg::CfgW-1:0] cfg_wdata
);
  import rzm_pkg::*;
  logic [CfgW-1:0] window_size;
  rzm_cmd_t cmd;
  rzm_sts_t sts;
  logic [31:0] momentum, zscore;
  logic [StampW-1:0] stamp_out;

  always_ff @(posedge clk) begin
    if (rst) window_size <= WindowReset;
    else if (cfg_we) window_size <= cfg_wdata;
  end

  rzm_ctrl u_ctrl (
    .clk, .rst, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .cmd, .sts
  );

  rzm_datapath #(.WindowMax(WindowMax)) u_dp (
    .clk, .rst, .window_size, .cmd, .sts,
    .price_in(s_tdata[23:0]), .stamp_in(s_tdata[87:24]),
    .momentum, .zscore, .stamp_out, .zero_base(m_tuser)
  );

  assign m_tdata = {stamp_out, zscore, momentum};
endmodule

@@ hw/rtl/rzm_datapath.sv @@
// Datapath: price ring, running sums, one shared iterative divider and square root.
// Depends on rzm_pkg.
module rzm_datapath #(
  parameter int WindowMax = rzm_pkg::WindowMaxDefault,
  parameter int AW = $clog2(WindowMax)
) (
  input  logic clk,
  input  logic rst,
  input  logic [rzm_pkg::CfgW-1:0] window_size,
  input  rzm_pkg::rzm_cmd_t cmd,
  output rzm_pkg::rzm_sts_t sts,
  input  logic [rzm_pkg::PriceW-1:0] price_in,
  input  logic [rzm_pkg::StampW-1:0] stamp_in,
  output logic [31:0] momentum,
  output logic [31:0] zscore,
  output logic [rzm_pkg::StampW-1:0] stamp_out,
  output logic zero_base
);
  import rzm_pkg::*;
  localparam int CW = AW + 1;
  localparam int SW = PriceW + CW;
  localparam int QW = 2 * PriceW + CW;

  logic [PriceW-1:0] ring [WindowMax];
  logic [PriceW-1:0] rd_data;
  logic [AW-1:0] write_slot;
  logic [CW-1:0] fill_count;
  logic [SW-1:0] running_sum;
  logic [QW-1:0] running_square_sum;
  logic [PriceW-1:0] price;
  logic [StampW-1:0] stamp;
  logic [CW-1:0] win;
  logic [AW-1:0] rd_addr;
  logic [CW-1:0] rd_diff;

  always_comb begin
    if (window_size == '0) win = CW'(1);
    else if (int'(window_size) > WindowMax) win = CW'(WindowMax);
    else win = CW'(window_size);
  end

  // oldest slot: write_slot - fill_count, wrapped into the ring depth
  assign rd_diff = {1'b0, write_slot} - fill_count;
  assign rd_addr = rd_diff[CW-1] ? AW'(rd_diff + CW'(WindowMax)) : AW'(rd_diff);

  always_ff @(posedge clk) begin
    if (cmd.rd_old || cmd.rd_base) rd_data <= ring[rd_addr];
    if (cmd.add_new) ring[write_slot] <= price;
  end

  logic [2*PriceW-1:0] old_sq, new_sq;
  assign old_sq = rd_data * rd_data;
  assign new_sq = price * price;

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot <= '0;
      fill_count <= '0;
      running_sum <= '0;
      running_square_sum <= '0;
    end else begin
      if (cmd.rm_old) begin
        running_sum <= running_sum - SW'(rd_data);
        running_square_sum <= running_square_sum - QW'(old_sq);
        fill_count <= fill_count - CW'(1);
      end
      if (cmd.add_new) begin
        running_sum <= running_sum + SW'(price);
        running_square_sum <= running_square_sum + QW'(new_sq);
        write_slot <= (write_slot == AW'(WindowMax - 1)) ? '0 : write_slot + AW'(1);
        fill_count <= fill_count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      price <= price_in;
      stamp <= stamp_in;
    end
  end

  assign sts.do_remove = (fill_count >= win) && (fill_count != '0);
  assign sts.emit = fill_count >= win;

  // Sequenced arithmetic: one shared restoring divider and a sqrt unit.
  typedef enum logic [7:0] {
    A_IDLE = 8'b0000_0001, A_MEAN = 8'b0000_0010, A_MSQ = 8'b0000_0100,
    A_VAR  = 8'b0000_1000, A_SQRT = 8'b0001_0000, A_MOM = 8'b0010_0000,
    A_ZS   = 8'b0100_0000, A_DONE = 8'b1000_0000
  } aseq_t;
  aseq_t aseq;

  // 64-bit dividend, divisor up to 64 bits, one quotient bit per cycle
  logic [63:0] dv_num, dv_den, dv_q;
  logic [64:0] dv_rem;
  logic [6:0] step;
  logic [64:0] trial;
  assign trial = {dv_rem[63:0], dv_num[63]} - {1'b0, dv_den};

  logic [63:0] mean, msq, var_v, sd;
  logic [63:0] sq_v, sq_root, sq_bit;
  logic [64:0] sq_sum;
  assign sq_sum = {1'b0, sq_root} + {1'b0, sq_bit};

  logic [31:0] m_lo;
  logic [63:0] msq_hi, mm;
  logic [PriceW+7:0] pnum;
  logic zneg;
  logic [63:0] zmag;
  logic [31:0] mom_r;
  logic zb_r;

  assign pnum = {price, 8'd0};
  assign msq_hi = {msq[47:0], 16'd0};

  always_ff @(posedge clk) begin
    if (rst) begin
      aseq <= A_IDLE;
      step <= '0;
    end else begin
      case (aseq)
        A_IDLE: begin
          if (cmd.div_start) begin
            dv_num <= 64'({running_sum, 8'd0});
            dv_den <= 64'(fill_count);
            dv_rem <= '0;
            step <= 7'd64;
            aseq <= A_MEAN;
          end
        end
        A_MEAN, A_MSQ, A_MOM, A_ZS: begin
          if (step != '0) begin
            if (!trial[64]) dv_rem <= {1'b0, trial[63:0]};
            else dv_rem <= {dv_rem[63:0], dv_num[63]};
            dv_q <= {dv_q[62:0], ~trial[64]};
            dv_num <= {dv_num[62:0], 1'b0};
            step <= step - 7'd1;
          end else begin
            dv_rem <= '0;
            step <= 7'd64;
            case (aseq)
              A_MEAN: begin
                mean <= dv_q;
                dv_num <= 64'(running_square_sum);
                dv_den <= 64'(fill_count);
                aseq <= A_MSQ;
              end
              A_MSQ: begin
                msq <= dv_q;
                m_lo <= mean[31:0];
                aseq <= A_VAR;
              end
              A_MOM: begin
                if (dv_q > 64'h7FFF_FFFF + 64'd65536) mom_r <= 32'h7FFF_FFFF;
                else mom_r <= 32'(dv_q - 64'd65536);
                if (sd == '0) begin
                  zneg <= 1'b0;
                  zmag <= '0;
                  aseq <= A_DONE;
                end else begin
                  zneg <= 64'(pnum) < mean;
                  dv_num <= (64'(pnum) < mean) ? (mean - 64'(pnum)) << 16
                                               : (64'(pnum) - mean) << 16;
                  dv_den <= sd;
                  aseq <= A_ZS;
                end
              end
              default: begin
                zmag <= dv_q;
                aseq <= A_DONE;
              end
            endcase
          end
        end
        A_VAR: begin
          // single 32x32 multiply, registered
          mm <= m_lo * m_lo;
          if (step == 7'd63) begin
            var_v <= (msq_hi > mm) ? msq_hi - mm : '0;
            sq_root <= '0;
            sq_bit <= 64'h4000_0000_0000_0000;
            aseq <= A_SQRT;
          end else begin
            step <= step - 7'd1;
          end
        end
        A_SQRT: begin
          if (step == 7'd63) sq_v <= var_v;
          if (step != 7'd63 && sq_bit != '0) begin
            if ({1'b0, sq_v} >= sq_sum) begin
              sq_v <= sq_v - sq_sum[63:0];
              sq_root <= (sq_root >> 1) + sq_bit;
            end else begin
              sq_root <= sq_root >> 1;
            end
            sq_bit <= sq_bit >> 2;
          end else if (step != 7'd63) begin
            sd <= sq_root;
            zb_r <= (rd_data == '0);
            dv_num <= {16'd0, price, 24'd0} >> 8;
            dv_den <= (rd_data == '0) ? 64'd1 : 64'(rd_data);
            dv_rem <= '0;
            step <= 7'd64;
            aseq <= A_MOM;
          end
          if (step == 7'd63) step <= 7'd62;
        end
        A_DONE: aseq <= A_IDLE;
        default: aseq <= A_IDLE;
      endcase
    end
  end

  assign sts.calc_done = (aseq == A_DONE);

  logic [31:0] zbits;
  always_comb begin
    if (zneg) zbits = (zmag > 64'h8000_0000) ? 32'h8000_0000 : 32'(64'd0 - zmag);
    else zbits = (zmag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : zmag[31:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      momentum <= zb_r ? 32'h7FFF_FFFF : mom_r;
      zscore <= zbits;
      stamp_out <= stamp;
      zero_base <= zb_r;
    end
  end
endmodule

@@ hw/rtl/rzm_ctrl.sv @@
// Controller: sequences one request through update, arithmetic and output.
// Depends on rzm_pkg.
module rzm_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  output logic m_tvalid,
  input  logic m_tready,
  output rzm_pkg::rzm_cmd_t cmd,
  input  rzm_pkg::rzm_sts_t sts
);
  import rzm_pkg::*;
  typedef enum logic [6:0] {
    S_IDLE = 7'b000_0001, S_RDOLD = 7'b000_0010, S_RMOLD = 7'b000_0100,
    S_ADD  = 7'b000_1000, S_BASE  = 7'b001_0000, S_CALC  = 7'b010_0000,
    S_OUT  = 7'b100_0000
  } state_t;
  state_t state, state_next;
  logic pend;

  assign s_tready = (state == S_IDLE) && !(m_tvalid && !m_tready);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: if (s_tvalid && s_tready) begin
        cmd.load = 1'b1;
        state_next = S_RDOLD;
      end
      S_RDOLD: begin
        cmd.rd_old = sts.do_remove;
        state_next = S_RMOLD;
      end
      S_RMOLD: begin
        cmd.rm_old = sts.do_remove;
        state_next = S_ADD;
      end
      S_ADD: begin
        cmd.add_new = 1'b1;
        state_next = S_BASE;
      end
      S_BASE: begin
        if (sts.emit) begin
          cmd.rd_base = 1'b1;
          cmd.div_start = 1'b1;
          state_next = S_CALC;
        end else state_next = S_IDLE;
      end
      S_CALC: if (sts.calc_done) state_next = S_OUT;
      S_OUT: if (!pend || m_tready) begin
        cmd.out_load = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign pend = m_tvalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end
endmodule

@@ hw/rtl/rzm_checker.sv @@
// Port-level checker for rolling_zscore_momentum, bound to the top level.
// Depends on rolling_zscore_momentum_macros.svh.
`include "rolling_zscore_momentum_macros.svh"
module rzm_checker (
  input logic clk,
  input logic rst,
  input logic s_tvalid,
  input logic s_tready,
  input logic m_tvalid,
  input logic m_tready,
  input logic [127:0] m_tdata
);
  `RZM_ASSERT_NXT(a_one_inflight, clk, rst, s_tvalid && s_tready, !s_tready, "second request taken")
  `RZM_ASSERT_IMP(a_no_take_when_blocked, clk, rst, m_tvalid && !m_tready, !s_tready, "took request while output stalled")
  `RZM_ASSERT_NXT(a_hold_out, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled output changed")
endmodule

bind rolling_zscore_momentum rzm_checker u_rzm_checker (
  .clk, .rst, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata
);

@@ tb/rolling_zscore_momentum_test.sv @@
// Testbench for rolling_zscore_momentum: drives price ticks, predicts momentum and
// z-score from its own window model, and compares every result field by field.
// Depends on rzm_pkg and the rolling_zscore_momentum RTL.
module rolling_zscore_momentum_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [63:0] stamp;
    logic        zero_base;
    logic [31:0] zscore;
    logic [31:0] momentum;
  } tick_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [87:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [127:0] m_tdata;
  logic m_tuser;
  logic cfg_we = 1'b0;
  logic [rzm_pkg::CfgW-1:0] cfg_wdata = '0;

  // window model
  logic [23:0] price_hist [64];
  int unsigned next_slot;
  int unsigned held;
  logic [63:0] price_sum;
  logic [63:0] square_sum;
  logic [6:0] window_reg;

  // predicted results, written by the predictor and read by the checker
  tick_result_t result_slots [8];
  int unsigned results_in = 0;
  int unsigned results_out = 0;
  int errors = 0;
  longint cycles = 0;
  bit send_gaps = 1'b1;
  bit recv_gaps = 1'b1;

  rolling_zscore_momentum i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 64'd4000000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Advance the window model by one tick; record a result when the window is full.
  task automatic predict_tick(logic [23:0] price, logic [63:0] stamp);
    int unsigned win;
    int unsigned n;
    logic [63:0] old;
    logic [63:0] mean;
    logic [63:0] mean_sq;
    logic [63:0] hi;
    logic [63:0] var_v;
    logic [63:0] sd;
    logic [63:0] pnum;
    logic [63:0] mag;
    logic [63:0] p;
    longint mom;
    tick_result_t r;
    p = {40'd0, price};
    win = (window_reg == 7'd0) ? 1 : (window_reg > 7'd64) ? 64 : int'(window_reg);
    if (held >= win && held > 0) begin
      old = {40'd0, price_hist[6'((next_slot + 64 - held) % 64)]};
      price_sum = price_sum - old;
      square_sum = square_sum - old * old;
      held = held - 1;
    end
    price_hist[6'(next_slot)] = price;
    price_sum = price_sum + p;
    square_sum = square_sum + p * p;
    next_slot = (next_slot + 1) % 64;
    held = held + 1;
    if (held < win) return;
    n = held;
    mean = (price_sum << 8) / n;
    mean_sq = square_sum / n;
    hi = mean_sq << 16;
    var_v = (hi > mean * mean) ? hi - mean * mean : 64'd0;
    sd = int_sqrt(var_v);
    old = {40'd0, price_hist[6'((next_slot + 64 - n) % 64)]};
    if (old == 0) begin
      r.momentum = 32'h7FFFFFFF;
      r.zero_base = 1'b1;
    end else begin
      mom = longint'((p << 16) / old) - 65536;
      if (mom > 64'sh7FFFFFFF) mom = 64'sh7FFFFFFF;
      r.momentum = mom[31:0];
      r.zero_base = 1'b0;
    end
    pnum = p << 8;
    if (sd == 0) begin
      r.zscore = '0;
    end else if (pnum < mean) begin
      mag = ((mean - pnum) << 16) / sd;
      if (mag > 64'h80000000) mag = 64'h80000000;
      r.zscore = 32'(64'd0 - mag);
    end else begin
      mag = ((pnum - mean) << 16) / sd;
      if (mag > 64'h7FFFFFFF) mag = 64'h7FFFFFFF;
      r.zscore = mag[31:0];
    end
    r.stamp = stamp;
    result_slots[3'(results_in)] = r;
    results_in = results_in + 1;
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
  endtask

  // Result checker and output stall generator.
  always @(posedge clk) begin
    tick_result_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (results_in == results_out) begin
        report_mismatch("unexpected result", m_tdata[63:0], 64'd0);
      end else begin
        e = result_slots[3'(results_out)];
        results_out = results_out + 1;
        if (m_tdata[31:0] !== e.momentum)
          report_mismatch("momentum", 64'(m_tdata[31:0]), 64'(e.momentum));
        if (m_tdata[63:32] !== e.zscore)
          report_mismatch("zscore", 64'(m_tdata[63:32]), 64'(e.zscore));
        if (m_tdata[127:64] !== e.stamp)
          report_mismatch("stamp_out", m_tdata[127:64], e.stamp);
        if (m_tuser !== e.zero_base)
          report_mismatch("zero_base", 64'(m_tuser), 64'(e.zero_base));
      end
    end
    m_tready <= !recv_gaps || ($urandom_range(99) >= 25);
  end

  task automatic send_tick(logic [23:0] price, logic [63:0] stamp);
    while (send_gaps && $urandom_range(99) < 25) @(posedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= {stamp, price};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_tick(price, stamp);
    // drop the request before the next tick
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (results_in != results_out) @(posedge clk);
    // a non-emitting tick may still be in flight
    repeat (20) @(posedge clk);
  endtask

  task automatic write_window(logic [6:0] value);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    window_reg = value;
  endtask

  function automatic logic [23:0] rand_price();
    case ($urandom_range(5))
      0: return 24'h0;
      1: return 24'hFFFFFF;
      2: return 24'($urandom_range(255));
      3: return 24'h640000 + 24'($urandom_range(2047));
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    // zero base with zero price, flat window, extremes
    write_window(7'd2);
    send_tick(24'h0, 64'h0);
    send_tick(24'h0, 64'hFFFFFFFFFFFFFFFF);
    send_tick(24'hFFFFFF, 64'h5555555555555555);
    send_tick(24'h0, 64'hAAAAAAAAAAAAAAAA);
    send_tick(24'h000001, 64'd1);
    send_tick(24'hFFFFFF, 64'd2);
    send_tick(24'h000100, 64'd3);
    send_tick(24'h000100, 64'd4);
    write_window(7'd0);
    send_tick(24'h123456, 64'd5);
    send_tick(24'hABCDEF, 64'd6);
    write_window(7'd127);
    repeat (8) send_tick(rand_price(), {$urandom, $urandom});
  endtask

  task automatic test_random_window(logic [6:0] win, int count);
    logic [23:0] base;
    write_window(win);
    base = rand_price();
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(3) == 0) base = rand_price();
      else base = base + 24'($urandom_range(511)) - 24'd256;
      send_tick(base, {$urandom, $urandom});
    end
  endtask

  initial begin
    window_reg = rzm_pkg::WindowReset;
    next_slot = 0;
    held = 0;
    price_sum = 0;
    square_sum = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random_window(7'd20, 300);
    test_random_window(7'd64, 300);
    test_random_window(7'd1, 200);
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    test_random_window(7'd5, 300);
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
    test_random_window(7'd3, 200);
    test_random_window(7'd100, 200);
    test_random_window(7'($urandom_range(127)), 250);
    test_random_window(7'd2, 250);

    wait_drained();
    repeat (300) @(posedge clk);
    if (errors == 0 && results_in == results_out) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
